// ===== src/awrs_pkg.sv =====
// ----------------------------------------------------------------------------
// awrs_pkg
// Shared sizes, codes and controller/datapath interface types for the
// alternating weighted range sum tree.
// ----------------------------------------------------------------------------
package awrs_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int TREE_SLOTS   = 2 * MAX_ELEMENTS;
  localparam int ADDR_W       = $clog2(TREE_SLOTS);
  localparam int PTR_W        = $clog2(TREE_SLOTS + 1);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  localparam int IDX_W = 10;
  localparam int VAL_W = 16;
  localparam int CFG_W = 11;
  localparam int SV_W  = 28;
  localparam int WV_W  = 40;

  // width for index arithmetic and compares that never wraps
  localparam int CALC_W = (PTR_W > IDX_W) ? (PTR_W + 1) : (IDX_W + 1);

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } awrs_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEAF,
    ST_UPD_WALK,
    ST_Q_LEFT,
    ST_Q_RIGHT,
    ST_Q_MUL,
    ST_Q_FIN
  } awrs_state_t;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic load;
    logic leaf_wr;
    logic walk_step;
    logic q_left;
    logic q_right;
    logic q_mul;
    logic q_fin;
  } awrs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic upd_ok;
    logic leaf_gt1;
    logic up_gt1;
    logic l_lt_r;
    logic out_free;
  } awrs_sts_t;

endpackage

// ===== src/awrs_ram.sv =====
// ----------------------------------------------------------------------------
// awrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module awrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/awrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// awrs_ctrl
// Sequencer: clearing pass, update walk up the trees, query level walk and
// result finish.
// ----------------------------------------------------------------------------
module awrs_ctrl
  import awrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  input  logic      cfg_valid,
  input  awrs_sts_t sts,
  output logic      in_ready,
  output awrs_cmd_t cmd
);

  awrs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.load = 1'b1;
          if (in_cmd == CMD_QUERY) begin
            state_nxt = ST_Q_LEFT;
          end else if (sts.upd_ok) begin
            state_nxt = ST_UPD_LEAF;
          end
        end
      end
      ST_UPD_LEAF: begin
        cmd.leaf_wr = 1'b1;
        state_nxt   = sts.leaf_gt1 ? ST_UPD_WALK : ST_IDLE;
      end
      ST_UPD_WALK: begin
        cmd.walk_step = 1'b1;
        state_nxt     = sts.up_gt1 ? ST_UPD_WALK : ST_IDLE;
      end
      ST_Q_LEFT: begin
        if (sts.l_lt_r) begin
          cmd.q_left = 1'b1;
          state_nxt  = ST_Q_RIGHT;
        end else begin
          state_nxt = ST_Q_MUL;
        end
      end
      ST_Q_RIGHT: begin
        cmd.q_right = 1'b1;
        state_nxt   = ST_Q_LEFT;
      end
      ST_Q_MUL: begin
        cmd.q_mul = 1'b1;
        state_nxt = ST_Q_FIN;
      end
      ST_Q_FIN: begin
        if (sts.out_free) begin
          cmd.q_fin = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    // a new element count invalidates the leaf layout: restart the clear
    if (cfg_valid) begin
      cmd.clr_start = 1'b1;
      state_nxt     = ST_CLEAR;
    end
  end

endmodule

// ===== src/awrs_dp.sv =====
// ----------------------------------------------------------------------------
// awrs_dp
// Datapath: both tree RAMs, leaf and node arithmetic, range walk pointers,
// accumulators, final combine and the output register.
// ----------------------------------------------------------------------------
module awrs_dp
  import awrs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [IDX_W-1:0]        in_first_index,
  input  logic [IDX_W-1:0]        in_last_index,
  input  logic [VAL_W-1:0]        in_new_value,
  input  logic                    cfg_valid,
  input  logic [CFG_W-1:0]        cfg_elements_used,
  input  awrs_cmd_t               cmd,
  output awrs_sts_t               sts,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [WV_W-1:0]  out_query_sum
);

  logic [CNT_W-1:0]  n_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [IDX_W-1:0]  first_r;
  logic [VAL_W-1:0]  value_r;
  logic [ADDR_W-1:0] node_r;
  logic [SV_W-1:0]   cur_p_r;
  logic [WV_W-1:0]   cur_w_r;
  logic [PTR_W-1:0]  l_r, r_r;
  logic              rd_pend_r;
  logic [SV_W-1:0]   acc_p_r;
  logic [WV_W-1:0]   acc_w_r;
  logic [WV_W-1:0]   prod_r;
  logic              out_valid_r;
  logic [WV_W-1:0]   out_sum_r;

  logic [CNT_W-1:0]  n_nxt;
  logic [CALC_W-1:0] first_c, last_c, n_c, lim_c;
  logic              q_empty;
  logic [ADDR_W-1:0] leaf_node, up_node;
  logic [IDX_W:0]    pos1;
  logic [VAL_W+IDX_W:0] mag;
  logic [SV_W-1:0]   sv_mag, leaf_p, sum_p;
  logic [WV_W-1:0]   wv_mag, leaf_w, sum_w;
  logic [PTR_W-1:0]  r_dec;
  logic [WV_W-1:0]   pa, fa, diff;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [SV_W-1:0]   wdata_p, rdata_p;
  logic [WV_W-1:0]   wdata_w, rdata_w;

  // element count clamp: zero acts as one, above the maximum as the maximum
  always_comb begin
    if (cfg_elements_used == '0) begin
      n_nxt = CNT_W'(1);
    end else if (32'(cfg_elements_used) > MAX_ELEMENTS) begin
      n_nxt = CNT_W'(MAX_ELEMENTS);
    end else begin
      n_nxt = CNT_W'(cfg_elements_used);
    end
  end

  // load-time range setup from the input word
  always_comb begin
    first_c = CALC_W'(in_first_index);
    last_c  = CALC_W'(in_last_index);
    n_c     = CALC_W'(n_r);
    lim_c   = (last_c >= n_c) ? (n_c - CALC_W'(1)) : last_c;
    q_empty = first_c > lim_c;
  end

  // leaf values and the walk up
  always_comb begin
    leaf_node = ADDR_W'(CALC_W'(first_r) + CALC_W'(n_r));
    up_node   = node_r >> 1;
    pos1      = {1'b0, first_r} + (IDX_W + 1)'(1);
    mag       = {{(IDX_W + 1){1'b0}}, value_r} * {{VAL_W{1'b0}}, pos1};
    sv_mag    = {{(SV_W - VAL_W){1'b0}}, value_r};
    wv_mag    = {{(WV_W - VAL_W - IDX_W - 1){1'b0}}, mag};
    leaf_p    = first_r[0] ? -sv_mag : sv_mag;
    leaf_w    = first_r[0] ? -wv_mag : wv_mag;
    sum_p     = cur_p_r + rdata_p;
    sum_w     = cur_w_r + rdata_w;
    r_dec     = r_r[0] ? (r_r - PTR_W'(1)) : r_r;
  end

  // final combine operands
  always_comb begin
    pa   = {{(WV_W - SV_W){acc_p_r[SV_W-1]}}, acc_p_r};
    fa   = {{(WV_W - IDX_W){1'b0}}, first_r};
    diff = acc_w_r - prod_r;
  end

  // RAM port steering
  always_comb begin
    we      = cmd.clr_step | cmd.leaf_wr | cmd.walk_step;
    waddr   = clr_cnt_r;
    wdata_p = '0;
    wdata_w = '0;
    if (cmd.leaf_wr) begin
      waddr   = leaf_node;
      wdata_p = leaf_p;
      wdata_w = leaf_w;
    end else if (cmd.walk_step) begin
      waddr   = up_node;
      wdata_p = sum_p;
      wdata_w = sum_w;
    end
    if (cmd.q_right) begin
      raddr = ADDR_W'(r_r - PTR_W'(1));
    end else if (cmd.q_left) begin
      raddr = ADDR_W'(l_r);
    end else if (cmd.walk_step) begin
      raddr = up_node ^ ADDR_W'(1);
    end else begin
      raddr = leaf_node ^ ADDR_W'(1);
    end
  end

  awrs_ram #(.WIDTH(SV_W), .DEPTH(TREE_SLOTS)) u_sv_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata_p),
    .raddr (raddr),
    .rdata (rdata_p)
  );

  awrs_ram #(.WIDTH(WV_W), .DEPTH(TREE_SLOTS)) u_wv_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata_w),
    .raddr (raddr),
    .rdata (rdata_w)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= CNT_W'(MAX_ELEMENTS);
      clr_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        n_r <= n_nxt;
      end
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      rd_pend_r <= (cmd.q_left & l_r[0]) | (cmd.q_right & r_r[0]);
      if (cmd.q_fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= in_first_index;
      value_r <= in_new_value;
      acc_p_r <= '0;
      acc_w_r <= '0;
      if (q_empty) begin
        l_r <= '0;
        r_r <= '0;
      end else begin
        l_r <= PTR_W'(first_c + n_c);
        r_r <= PTR_W'(lim_c + CALC_W'(1) + n_c);
      end
    end else begin
      if (rd_pend_r) begin
        acc_p_r <= acc_p_r + rdata_p;
        acc_w_r <= acc_w_r + rdata_w;
      end
      if (cmd.q_left && l_r[0]) begin
        l_r <= l_r + PTR_W'(1);
      end
      if (cmd.q_right) begin
        l_r <= l_r >> 1;
        r_r <= r_dec >> 1;
      end
    end
    if (cmd.leaf_wr) begin
      node_r  <= leaf_node;
      cur_p_r <= leaf_p;
      cur_w_r <= leaf_w;
    end else if (cmd.walk_step) begin
      node_r  <= up_node;
      cur_p_r <= sum_p;
      cur_w_r <= sum_w;
    end
    if (cmd.q_mul) begin
      prod_r <= pa * fa;
    end
    if (cmd.q_fin) begin
      out_sum_r <= first_r[0] ? -diff : diff;
    end
  end

  always_comb begin
    sts.clr_last = clr_cnt_r == ADDR_W'(TREE_SLOTS - 1);
    sts.upd_ok   = first_c < n_c;
    sts.leaf_gt1 = leaf_node > ADDR_W'(1);
    sts.up_gt1   = up_node > ADDR_W'(1);
    sts.l_lt_r   = l_r < r_r;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_query_sum = out_sum_r;

endmodule

// ===== src/alternating_weighted_range_sum_tree.sv =====
// ----------------------------------------------------------------------------
// alternating_weighted_range_sum_tree
// Two bottom-up segment trees (sign-alternated values and position-weighted
// values) with point update and alternating weighted range sum query.
// ----------------------------------------------------------------------------
// Update word: one tree level per cycle from accept to ready again, with no
//   stall (sibling read overlaps the parent write).
// Query word: a left and a right step per tree level, as each tree RAM has a
//   single read port, then a multiply and a finish step; no result for updates.
// Reset, and every write of elements_used, runs a clearing pass over all 2048
//   slots of both tree RAMs; no input word is accepted until it ends.
// ----------------------------------------------------------------------------
module alternating_weighted_range_sum_tree
  import awrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_cmd,
  input  logic [IDX_W-1:0]       in_first_index,
  input  logic [IDX_W-1:0]       in_last_index,
  input  logic [VAL_W-1:0]       in_new_value,
  // result words
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [WV_W-1:0] out_query_sum,
  // element count register
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_elements_used
);

  awrs_cmd_t cmd;
  awrs_sts_t sts;

  // The register is always writable; a write restarts the clearing pass,
  // since the leaf offset of both trees follows the element count.
  assign cfg_ready = 1'b1;

  // Sequencer: decides which walk step runs in each cycle.
  awrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // Datapath: tree RAMs, walk pointers, accumulators and the output register.
  // The output register decouples the result from the next input word.
  awrs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_first_index    (in_first_index),
    .in_last_index     (in_last_index),
    .in_new_value      (in_new_value),
    .cfg_valid         (cfg_valid),
    .cfg_elements_used (cfg_elements_used),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_query_sum     (out_query_sum)
  );

endmodule
